### hw/rtl/trap_pkg.sv
// shared types and constants for the trapezoid motion profile block
// item structs, config struct, datapath command and status codes
package trap_pkg;

  // working width of the shared multiplier, divider and square root
  localparam int VW = 64;

  typedef struct packed {
    logic        kind;
    logic [11:0] distance_mm;
  } req_t;

  typedef struct packed {
    logic [19:0] position;
    logic [15:0] speed;
    logic [1:0]  phase;
    logic        done_res;
  } rsp_t;

  typedef struct packed {
    logic [15:0] max_speed;
    logic [19:0] accel_rate;
    logic [13:0] tick_rate;
    logic [15:0] pulses_per_mm;
  } cfg_t;

  // register indexes
  localparam logic [1:0] REG_MAX_SPEED     = 2'd0;
  localparam logic [1:0] REG_ACCEL_RATE    = 2'd1;
  localparam logic [1:0] REG_TICK_RATE     = 2'd2;
  localparam logic [1:0] REG_PULSES_PER_MM = 2'd3;

  localparam logic [15:0] RST_MAX_SPEED     = 16'd13000;
  localparam logic [19:0] RST_ACCEL_RATE    = 20'd20000;
  localparam logic [13:0] RST_TICK_RATE     = 14'd100;
  localparam logic [15:0] RST_PULSES_PER_MM = 16'd28608;

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_ACCEL  = 2'd1;
  localparam logic [1:0] PH_CRUISE = 2'd2;
  localparam logic [1:0] PH_DECEL  = 2'd3;

  localparam logic [19:0] POS_MAX = 20'hFFFFF;

  // datapath operations
  localparam logic [4:0] OP_NONE   = 5'd0;
  localparam logic [4:0] OP_LOAD   = 5'd1;
  localparam logic [4:0] OP_DRAW   = 5'd2;
  localparam logic [4:0] OP_STEP   = 5'd3;
  localparam logic [4:0] OP_PTR    = 5'd4;
  localparam logic [4:0] OP_NDIV   = 5'd5;
  localparam logic [4:0] OP_TRI    = 5'd6;
  localparam logic [4:0] OP_APMUL  = 5'd7;
  localparam logic [4:0] OP_APDIV  = 5'd8;
  localparam logic [4:0] OP_PROD   = 5'd9;
  localparam logic [4:0] OP_MS2    = 5'd10;
  localparam logic [4:0] OP_PMAX   = 5'd11;
  localparam logic [4:0] OP_SQRT   = 5'd12;
  localparam logic [4:0] OP_REM    = 5'd13;
  localparam logic [4:0] OP_CDIV   = 5'd14;
  localparam logic [4:0] OP_COMMIT = 5'd15;
  localparam logic [4:0] OP_PDIV   = 5'd16;
  localparam logic [4:0] OP_TICK   = 5'd17;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic need_lower;
    logic use_max;
    logic do_cruise;
  } status_t;

endpackage

### hw/rtl/trapezoid_motion_profile.sv
// trapezoid motion profile: a start item's time is set by the shared 64-step
// multiplier and divider, which work through the planning operations one after
// another, the peak-lowering square root among them; a tick item's time is set
// by the 64-step divide of the position sum. one item is worked at a time.
// rst is synchronous active high: registers return to their defaults, the profile
// goes idle with position, speed and tick counters at zero, no item is pending
module trapezoid_motion_profile import trap_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int TICK_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request items
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  // result items
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    cfg_wr;

  // config registers, written on the access phase of a write
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_speed     <= RST_MAX_SPEED;
      cfg.accel_rate    <= RST_ACCEL_RATE;
      cfg.tick_rate     <= RST_TICK_RATE;
      cfg.pulses_per_mm <= RST_PULSES_PER_MM;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MAX_SPEED:     cfg.max_speed     <= pwdata[15:0];
        REG_ACCEL_RATE:    cfg.accel_rate    <= pwdata[19:0];
        REG_TICK_RATE:     cfg.tick_rate     <= pwdata[13:0];
        REG_PULSES_PER_MM: cfg.pulses_per_mm <= pwdata[15:0];
        default:           cfg.max_speed     <= cfg.max_speed;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_MAX_SPEED:     prdata = 32'(cfg.max_speed);
      REG_ACCEL_RATE:    prdata = 32'(cfg.accel_rate);
      REG_TICK_RATE:     prdata = 32'(cfg.tick_rate);
      REG_PULSES_PER_MM: prdata = 32'(cfg.pulses_per_mm);
      default:           prdata = '0;
    endcase
  end

  // sequencer: takes an item when idle, steps the datapath through
  // planning or one tick, then loads the result register
  trap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_kind  (req.kind),
    .req_ready (req_ready),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: profile state, multiplier, divider, square root
  trap_dp #(
    .FRAC_BITS (FRAC_BITS),
    .TICK_BITS (TICK_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

  // one item at a time: no second accept right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("item accepted while previous one still in work");

  // a unit or state update is only commanded once the units are idle
  a_issue_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != OP_NONE) |-> !status.busy)
    else $error("datapath command issued while a unit is busy");

  // a result appears only from a commit or a tick update
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(cmd.op) == OP_COMMIT || $past(cmd.op) == OP_TICK))
    else $error("result valid without a result update");

endmodule

### hw/rtl/trap_mul.sv
// iterative shift-add multiplier, one multiplier bit per cycle
// depends on trap_pkg; product saturates at all ones
module trap_mul import trap_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [VW-1:0] a,
  input  logic [VW-1:0] b,
  output logic          busy,
  output logic          done,
  output logic [VW-1:0] prod
);

  localparam int CW = $clog2(VW + 1);

  logic [VW-1:0]   a_r;
  logic [VW-1:0]   b_r;
  logic [2*VW-1:0] acc;
  logic [CW-1:0]   cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(VW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc <= '0;
    end else if (busy) begin
      acc <= {acc[2*VW-2:0], 1'b0} + (b_r[VW-1] ? {{VW{1'b0}}, a_r} : {2*VW{1'b0}});
      b_r <= {b_r[VW-2:0], 1'b0};
    end
  end

  assign prod = (|acc[2*VW-1:VW]) ? {VW{1'b1}} : acc[VW-1:0];

endmodule

### hw/rtl/trap_div.sv
// restoring divider, one quotient bit per cycle
// depends on trap_pkg; gives quotient and a nonzero-remainder flag
module trap_div import trap_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [VW-1:0] num,
  input  logic [VW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [VW-1:0] quo,
  output logic          rem_nz
);

  localparam int CW = $clog2(VW + 1);

  logic [VW-1:0] q;
  logic [VW-1:0] rem;
  logic [VW-1:0] dv;
  logic [CW-1:0] cnt;
  logic [VW:0]   rem_sh;
  logic [VW:0]   diff;
  logic          fits;

  always_comb begin
    rem_sh = {rem, q[VW-1]};
    diff   = rem_sh - {1'b0, dv};
    fits   = rem_sh >= {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(VW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      dv  <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[VW-1:0];
        q   <= {q[VW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[VW-1:0];
        q   <= {q[VW-2:0], 1'b0};
      end
    end
  end

  assign quo    = q;
  assign rem_nz = |rem;

endmodule

### hw/rtl/trap_ctrl.sv
// sequencer for move planning and tick stepping
// depends on trap_pkg; drives datapath commands and owns the result valid
module trap_ctrl import trap_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  input  logic    req_kind,
  output logic    req_ready,
  input  logic    rsp_ready,
  output logic    rsp_valid,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_DRAW   = 5'd1;
  localparam logic [4:0] ST_STEP   = 5'd2;
  localparam logic [4:0] ST_PTR    = 5'd3;
  localparam logic [4:0] ST_NDIV   = 5'd4;
  localparam logic [4:0] ST_TRI    = 5'd5;
  localparam logic [4:0] ST_APMUL  = 5'd6;
  localparam logic [4:0] ST_APDIV  = 5'd7;
  localparam logic [4:0] ST_PROD   = 5'd8;
  localparam logic [4:0] ST_MS2    = 5'd9;
  localparam logic [4:0] ST_PMAX   = 5'd10;
  localparam logic [4:0] ST_SQRT   = 5'd11;
  localparam logic [4:0] ST_REM    = 5'd12;
  localparam logic [4:0] ST_CDIV   = 5'd13;
  localparam logic [4:0] ST_COMMIT = 5'd14;
  localparam logic [4:0] ST_PDIV   = 5'd15;
  localparam logic [4:0] ST_TICK   = 5'd16;

  logic [4:0] st;
  logic [4:0] st_next;
  logic       waiting;
  logic       waiting_next;
  logic       pass;
  logic       pass_next;
  logic       out_load;
  logic       out_free;
  logic [4:0] unit_op;
  logic [4:0] unit_follow;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (st == ST_IDLE);

  // operation and successor of each multi-cycle step
  always_comb begin
    unit_op     = OP_NONE;
    unit_follow = ST_IDLE;
    case (st)
      ST_DRAW:  begin unit_op = OP_DRAW;  unit_follow = ST_STEP;  end
      ST_STEP:  begin unit_op = OP_STEP;  unit_follow = ST_PTR;   end
      ST_PTR:   begin unit_op = OP_PTR;   unit_follow = ST_NDIV;  end
      ST_NDIV:  begin unit_op = OP_NDIV;  unit_follow = ST_TRI;   end
      ST_TRI:   begin unit_op = OP_TRI;   unit_follow = ST_APMUL; end
      ST_APMUL: begin unit_op = OP_APMUL; unit_follow = ST_APDIV; end
      ST_APDIV: begin
        unit_op = OP_APDIV;
        if (!pass && status.need_lower) begin
          unit_follow = ST_PROD;
        end else if (status.do_cruise) begin
          unit_follow = ST_REM;
        end else begin
          unit_follow = ST_COMMIT;
        end
      end
      ST_PROD:  begin unit_op = OP_PROD;  unit_follow = ST_MS2;   end
      ST_MS2:   begin
        unit_op     = OP_MS2;
        unit_follow = status.use_max ? ST_PMAX : ST_SQRT;
      end
      ST_SQRT:  begin unit_op = OP_SQRT;  unit_follow = ST_PTR;    end
      ST_REM:   begin unit_op = OP_REM;   unit_follow = ST_CDIV;   end
      ST_CDIV:  begin unit_op = OP_CDIV;  unit_follow = ST_COMMIT; end
      ST_PDIV:  begin unit_op = OP_PDIV;  unit_follow = ST_TICK;   end
      default: begin
        unit_op     = OP_NONE;
        unit_follow = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.op       = OP_NONE;
    st_next      = st;
    waiting_next = waiting;
    pass_next    = pass;
    out_load     = 1'b0;
    case (st)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.op    = OP_LOAD;
          pass_next = 1'b0;
          st_next   = (req_kind == KIND_TICK) ? ST_PDIV : ST_DRAW;
        end
      end
      ST_PMAX: begin
        cmd.op    = OP_PMAX;
        pass_next = 1'b1;
        st_next   = ST_PTR;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.op   = OP_COMMIT;
          out_load = 1'b1;
          st_next  = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (out_free) begin
          cmd.op   = OP_TICK;
          out_load = 1'b1;
          st_next  = ST_IDLE;
        end
      end
      default: begin
        if (!waiting) begin
          cmd.op       = unit_op;
          waiting_next = 1'b1;
        end else if (!status.busy) begin
          waiting_next = 1'b0;
          st_next      = unit_follow;
          if (st == ST_SQRT) begin
            pass_next = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      waiting   <= 1'b0;
      pass      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      st        <= st_next;
      waiting   <= waiting_next;
      pass      <= pass_next;
      rsp_valid <= out_load || (rsp_valid && !rsp_ready);
    end
  end

endmodule

### hw/rtl/trap_dp.sv
// planning and stepping datapath: profile state, shared arithmetic units
// depends on trap_pkg, trap_mul, trap_div; square root runs in place
module trap_dp import trap_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int TICK_BITS = 24
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  req_t    req,
  input  cmd_t    cmd,
  output status_t status,
  output rsp_t    rsp
);

  localparam int SW  = FRAC_BITS + 16;
  localparam int STW = FRAC_BITS + 20;
  localparam int DW  = FRAC_BITS + 20;
  localparam int PW  = FRAC_BITS + 34;
  localparam int TB  = TICK_BITS;
  localparam int SQW = $clog2(VW / 2 + 1);
  localparam logic [TB-1:0] NMAX = {2'b00, {(TB - 2){1'b1}}};
  localparam logic [TB-1:0] CMAX = {1'b0, {(TB - 1){1'b1}}};

  function automatic logic [TB-1:0] sat_ticks(input logic [VW:0] v, input logic [TB-1:0] mx);
    logic [TB-1:0] r;
    r = (v > (VW + 1)'(mx)) ? mx : v[TB-1:0];
    return r;
  endfunction

  function automatic logic [1:0] phase_of(input logic [TB:0] x, input logic [TB:0] n,
                                          input logic [TB:0] nc);
    logic [1:0] p;
    if (x < n) begin
      p = PH_ACCEL;
    end else if (x < nc) begin
      p = PH_CRUISE;
    end else begin
      p = PH_DECEL;
    end
    return p;
  endfunction

  // profile state
  logic [PW-1:0]  pos_accum;
  logic [SW-1:0]  speed_now;
  logic [STW-1:0] speed_step;
  logic [TB-1:0]  tick_count;
  logic [TB-1:0]  accel_ticks;
  logic [TB-1:0]  cruise_ticks;
  logic [1:0]     phase_now;
  logic [4:0]     cur_op;

  // planning scratch
  logic [11:0]    dist_mm;
  logic [27:0]    d_raw;
  logic [SW-1:0]  peak;
  logic [VW-1:0]  ap;
  logic [47:0]    prod;
  logic [31:0]    ms2;
  logic [VW-1:0]  mres;
  logic [PW-1:0]  pq;

  // square root unit
  logic [VW-1:0]  sq_x;
  logic [VW-1:0]  sq_r;
  logic [VW-1:0]  sq_bit;
  logic [VW-1:0]  sq_sum;
  logic [SQW-1:0] sq_cnt;
  logic           sq_busy;
  logic           sq_done;
  logic           sq_start;

  // shared unit hookup
  logic           mul_start;
  logic [VW-1:0]  mul_a;
  logic [VW-1:0]  mul_b;
  logic           mul_busy;
  logic           mul_done;
  logic [VW-1:0]  mul_prod;
  logic           div_start;
  logic [VW-1:0]  div_num;
  logic [VW-1:0]  div_den;
  logic           div_busy;
  logic           div_done;
  logic [VW-1:0]  div_quo;
  logic           div_rnz;
  logic [VW:0]    div_up;

  logic [19:0]    acc_e;
  logic [13:0]    tr_e;
  logic [DW-1:0]  d;
  logic [VW:0]    tw;

  // tick arithmetic
  logic [PW-1:0]  hq;
  logic [19:0]    pos_out;
  logic [TB:0]    n1;
  logic [TB:0]    nc;
  logic [TB:0]    total;
  logic [TB:0]    t1;
  logic [TB:0]    nxt;
  logic           last;
  logic [PW:0]    pos_sum;
  logic [PW:0]    cap;
  logic [PW-1:0]  pos_new;
  logic [SW-1:0]  speed_up;
  logic [SW-1:0]  speed_dn;

  assign acc_e  = (cfg.accel_rate == 20'd0) ? 20'd1 : cfg.accel_rate;
  assign tr_e   = (cfg.tick_rate == 14'd0) ? 14'd1 : cfg.tick_rate;
  assign d      = DW'(d_raw) << (FRAC_BITS - 8);
  assign tw     = {ap, 1'b0};
  assign div_up = {1'b0, div_quo} + (VW + 1)'(div_rnz);

  trap_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  trap_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .busy   (div_busy),
    .done   (div_done),
    .quo    (div_quo),
    .rem_nz (div_rnz)
  );

  // operand selection for the unit started by this command
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    case (cmd.op)
      OP_DRAW: begin
        mul_start = 1'b1;
        mul_a     = VW'(dist_mm);
        mul_b     = VW'(cfg.pulses_per_mm);
      end
      OP_STEP: begin
        div_start = 1'b1;
        div_num   = VW'(acc_e) << FRAC_BITS;
        div_den   = VW'(tr_e);
      end
      OP_PTR: begin
        mul_start = 1'b1;
        mul_a     = VW'(peak);
        mul_b     = VW'(tr_e);
      end
      OP_NDIV: begin
        div_start = 1'b1;
        div_num   = mres;
        div_den   = VW'(acc_e) << FRAC_BITS;
      end
      OP_TRI: begin
        mul_start = 1'b1;
        mul_a     = VW'(accel_ticks);
        mul_b     = VW'(accel_ticks) - VW'(1);
      end
      OP_APMUL: begin
        mul_start = 1'b1;
        mul_a     = VW'(speed_step);
        mul_b     = mres >> 1;
      end
      OP_APDIV: begin
        div_start = 1'b1;
        div_num   = mres;
        div_den   = VW'(tr_e);
      end
      OP_PROD: begin
        mul_start = 1'b1;
        mul_a     = VW'(acc_e);
        mul_b     = VW'(d_raw);
      end
      OP_MS2: begin
        mul_start = 1'b1;
        mul_a     = VW'(cfg.max_speed);
        mul_b     = VW'(cfg.max_speed);
      end
      OP_SQRT: begin
        sq_start = 1'b1;
      end
      OP_REM: begin
        mul_start = 1'b1;
        mul_a     = VW'(d) - tw[VW-1:0];
        mul_b     = VW'(tr_e);
      end
      OP_CDIV: begin
        div_start = 1'b1;
        div_num   = mres;
        div_den   = VW'(peak);
      end
      OP_PDIV: begin
        div_start = 1'b1;
        div_num   = VW'(pos_accum);
        div_den   = VW'(tr_e);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // tick sample and next state
  always_comb begin
    hq       = pq >> FRAC_BITS;
    pos_out  = (hq > PW'(POS_MAX)) ? POS_MAX : hq[19:0];
    n1       = (TB + 1)'(accel_ticks);
    nc       = n1 + (TB + 1)'(cruise_ticks);
    total    = (n1 << 1) + (TB + 1)'(cruise_ticks);
    t1       = (TB + 1)'(tick_count);
    nxt      = t1 + (TB + 1)'(1);
    last     = nxt >= total;
    pos_sum  = (PW + 1)'(pos_accum) + (PW + 1)'(speed_now);
    cap      = (PW + 1)'(tr_e) << (20 + FRAC_BITS);
    pos_new  = (pos_sum > cap) ? cap[PW-1:0] : pos_sum[PW-1:0];
    speed_up = speed_now + SW'(speed_step);
    speed_dn = (STW'(speed_now) > speed_step) ? speed_now - SW'(speed_step) : '0;
  end

  assign sq_sum = sq_r + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
      sq_cnt  <= '0;
    end else begin
      sq_done <= 1'b0;
      if (sq_start) begin
        sq_busy <= 1'b1;
        sq_cnt  <= SQW'(VW / 2);
      end else if (sq_busy) begin
        sq_cnt <= sq_cnt - SQW'(1);
        if (sq_cnt == SQW'(1)) begin
          sq_busy <= 1'b0;
          sq_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sq_start) begin
      sq_x   <= VW'({prod, 8'h00});
      sq_r   <= '0;
      sq_bit <= VW'(1) << (VW - 2);
    end else if (sq_busy) begin
      if (sq_x >= sq_sum) begin
        sq_x <= sq_x - sq_sum;
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // profile state: cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_accum    <= '0;
      speed_now    <= '0;
      speed_step   <= '0;
      tick_count   <= '0;
      accel_ticks  <= '0;
      cruise_ticks <= '0;
      phase_now    <= PH_IDLE;
      cur_op       <= OP_NONE;
    end else begin
      if (mul_start || div_start || sq_start) begin
        cur_op <= cmd.op;
      end
      if (cmd.op == OP_DRAW) begin
        cruise_ticks <= '0;
      end
      if (div_done) begin
        case (cur_op)
          OP_STEP: speed_step   <= div_quo[STW-1:0];
          OP_NDIV: accel_ticks  <= sat_ticks(div_up, NMAX);
          OP_CDIV: cruise_ticks <= sat_ticks(div_up, CMAX);
          default: speed_step   <= speed_step;
        endcase
      end
      if (cmd.op == OP_COMMIT) begin
        pos_accum  <= '0;
        speed_now  <= '0;
        tick_count <= '0;
        if (accel_ticks == '0) begin
          cruise_ticks <= '0;
          phase_now    <= PH_IDLE;
        end else begin
          phase_now <= PH_ACCEL;
        end
      end
      if (cmd.op == OP_TICK && phase_now != PH_IDLE) begin
        pos_accum  <= pos_new;
        tick_count <= nxt[TB-1:0];
        if (last) begin
          phase_now <= PH_IDLE;
          speed_now <= '0;
        end else begin
          if (nxt < n1) begin
            speed_now <= speed_up;
          end else if (nxt >= nc) begin
            speed_now <= speed_dn;
          end
          phase_now <= phase_of(nxt, n1, nc);
        end
      end
    end
  end

  // planning scratch and result register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      dist_mm <= req.distance_mm;
    end
    if (cmd.op == OP_DRAW || cmd.op == OP_PMAX) begin
      peak <= SW'(cfg.max_speed) << FRAC_BITS;
    end
    if (sq_done) begin
      peak <= SW'(sq_r) << (FRAC_BITS - 8);
    end
    if (mul_done) begin
      case (cur_op)
        OP_DRAW: d_raw <= mul_prod[27:0];
        OP_PROD: prod  <= mul_prod[47:0];
        OP_MS2:  ms2   <= mul_prod[31:0];
        default: mres  <= mul_prod;
      endcase
    end
    if (div_done) begin
      case (cur_op)
        OP_APDIV: ap <= div_quo;
        OP_PDIV:  pq <= div_quo[PW-1:0];
        default:  ap <= ap;
      endcase
    end
    if (cmd.op == OP_COMMIT) begin
      rsp <= '0;
    end
    if (cmd.op == OP_TICK) begin
      rsp.position <= pos_out;
      if (phase_now == PH_IDLE) begin
        rsp.speed    <= '0;
        rsp.phase    <= PH_IDLE;
        rsp.done_res <= 1'b0;
      end else begin
        rsp.speed    <= speed_now[FRAC_BITS +: 16];
        rsp.phase    <= phase_of(t1, n1, nc);
        rsp.done_res <= last;
      end
    end
  end

  always_comb begin
    status.busy       = mul_busy || mul_done || div_busy || div_done || sq_busy || sq_done;
    status.need_lower = tw > (VW + 1)'(d);
    status.do_cruise  = (peak != '0) && (tw < (VW + 1)'(d));
    status.use_max    = prod >= (48'(ms2) << 8);
  end

endmodule

### bench/tb_top.sv
// self-checking bench for trapezoid_motion_profile: random start and tick items,
// a bit-accurate profile predictor, apb register writes between phases
// depends on trap_pkg and the trapezoid_motion_profile rtl
module tb_top;
  import trap_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int F = 16;
  localparam bit [63:0] TICK_MAX = (64'd1 << 24) - 64'd1;
  localparam bit [63:0] P_MAX = 64'd1048575;
  localparam bit [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  trapezoid_motion_profile dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  req_t pend_q[$];     // items waiting to be offered
  rsp_t sample_q[$];   // predicted samples in acceptance order
  int n_acc = 0;
  int n_rsp = 0;
  int err_cnt = 0;
  bit calm;

  // no idling on either side for a stretch of items
  assign calm = (n_acc >= 400) && (n_acc < 520);

  // ---------------- profile predictor ----------------
  // register copies
  bit [63:0] r_ms = 64'd13000, r_acc = 64'd20000, r_tr = 64'd100, r_ppm = 64'd28608;
  // move state
  bit [63:0] pos_sum, spd, step, tick_idx, n_ramp, n_cruise;
  logic [1:0] ph_now = PH_IDLE;

  function automatic bit [63:0] acc_e();
    return (r_acc != 0) ? r_acc : 64'd1;  // zero rate acts as one
  endfunction

  function automatic bit [63:0] tr_e();
    return (r_tr != 0) ? r_tr : 64'd1;
  endfunction

  function automatic bit [63:0] ceil_div(bit [63:0] a, bit [63:0] b);
    return a / b + ((a % b) != 0 ? 64'd1 : 64'd0);
  endfunction

  function automatic bit [63:0] dbl(bit [63:0] v);
    return (v > ALL1 / 2) ? ALL1 : 2 * v;
  endfunction

  function automatic bit [63:0] ramp_len(bit [63:0] peak);
    bit [63:0] n;
    n = ceil_div(peak * tr_e(), acc_e() << F);
    return (n > TICK_MAX / 4) ? TICK_MAX / 4 : n;
  endfunction

  // distance covered during the ramp, product saturating
  function automatic bit [63:0] ramp_span(bit [63:0] n);
    bit [63:0] tri_n, prod;
    tri_n = (n != 0) ? (n * (n - 1)) / 2 : 64'd0;
    if (step != 0 && tri_n > ALL1 / step) prod = ALL1;
    else prod = step * tri_n;
    return prod / tr_e();
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] x);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [1:0] phase_at(bit [63:0] t);
    if (t < n_ramp) return PH_ACCEL;
    if (t < n_ramp + n_cruise) return PH_CRUISE;
    return PH_DECEL;
  endfunction

  function automatic logic [19:0] pos_now();
    bit [63:0] p;
    p = (pos_sum / tr_e()) >> F;
    return (p > P_MAX) ? P_MAX[19:0] : p[19:0];
  endfunction

  function automatic void plan_move(bit [63:0] mm);
    bit [63:0] d_raw, d, peak, n, ap, c, prod;
    d_raw = mm * r_ppm;         // q8.8 pulses
    d = d_raw << (F - 8);
    peak = r_ms << F;
    c = 0;
    step = (acc_e() << F) / tr_e();
    n = ramp_len(peak);
    ap = ramp_span(n);
    // short move: the ramps overlap, lower the peak
    if (dbl(ap) > d) begin
      prod = acc_e() * d_raw;
      if (prod >= ((r_ms * r_ms) << 8)) peak = r_ms << F;
      else peak = int_sqrt(prod << 8) << (F - 8);
      n = ramp_len(peak);
      ap = ramp_span(n);
    end
    if (peak != 0 && dbl(ap) < d) begin
      c = ceil_div((d - dbl(ap)) * tr_e(), peak);
      if (c > TICK_MAX / 2) c = TICK_MAX / 2;
    end
    n_ramp = n;
    n_cruise = (n != 0) ? c : 64'd0;
    pos_sum = 0;
    spd = 0;
    tick_idx = 0;
    ph_now = (n != 0) ? PH_ACCEL : PH_IDLE;  // empty move stays idle
  endfunction

  function automatic rsp_t next_sample(req_t r);
    rsp_t o;
    bit [63:0] nxt, total, cap;
    o = '0;
    if (r.kind == KIND_START) begin
      plan_move(64'(r.distance_mm));
      return o;
    end
    if (ph_now == PH_IDLE) begin
      o.position = pos_now();
      return o;
    end
    nxt = tick_idx + 1;
    total = 2 * n_ramp + n_cruise;
    cap = ((P_MAX + 1) * tr_e()) << F;
    o.position = pos_now();
    o.speed = spd[F +: 16];
    o.phase = phase_at(tick_idx);
    o.done_res = (nxt >= total);
    pos_sum = pos_sum + spd;
    if (pos_sum > cap) pos_sum = cap;
    if (nxt >= total) begin
      ph_now = PH_IDLE;
      spd = 0;
    end else begin
      if (nxt < n_ramp) spd = spd + step;
      else if (nxt >= n_ramp + n_cruise) spd = (spd > step) ? spd - step : 64'd0;
      ph_now = phase_at(nxt);
    end
    tick_idx = nxt;
    return o;
  endfunction

  // ---------------- request driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        sample_q.push_back(next_sample(req));
        n_acc++;
      end
      if (!req_valid || req_ready) begin
        if (pend_q.size() > 0 && (calm || $urandom_range(99) >= 11)) begin
          req <= pend_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result monitor ----------------
  int hold_left = 0;
  bit held = 1'b0;

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        n_rsp++;
        if (sample_q.size() == 0) begin
          $error("result with nothing expected: pos %0d speed %0d", rsp.position, rsp.speed);
          err_cnt++;
        end else begin
          want = sample_q.pop_front();
          if (rsp.position !== want.position) begin
            $error("position exp %0d got %0d", want.position, rsp.position);
            err_cnt++;
          end
          if (rsp.speed !== want.speed) begin
            $error("speed exp %0d got %0d", want.speed, rsp.speed);
            err_cnt++;
          end
          if (rsp.phase !== want.phase) begin
            $error("phase exp %0d got %0d", want.phase, rsp.phase);
            err_cnt++;
          end
          if (rsp.done_res !== want.done_res) begin
            $error("done_res exp %0d got %0d", want.done_res, rsp.done_res);
            err_cnt++;
          end
        end
      end
      // one long hold-off so the block backs up and stalls its input
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_ready <= 1'b0;
      end else if (n_rsp == 300 && !held) begin
        held <= 1'b1;
        hold_left <= 400;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= calm || ($urandom_range(99) >= 11);
      end
    end
  end

  // ---------------- watchdog ----------------
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------- stimulus ----------------
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAX_SPEED:  r_ms  = 64'(val[15:0]);
      REG_ACCEL_RATE: r_acc = 64'(val[19:0]);
      REG_TICK_RATE:  r_tr  = 64'(val[13:0]);
      default:        r_ppm = 64'(val[15:0]);
    endcase
  endtask

  task automatic set_regs(int ms, int acc, int tr, int ppm);
    reg_write(REG_MAX_SPEED, ms);
    reg_write(REG_ACCEL_RATE, acc);
    reg_write(REG_TICK_RATE, tr);
    reg_write(REG_PULSES_PER_MM, ppm);
  endtask

  task automatic push_item(logic k, int mm);
    req_t r;
    r.kind = k;
    r.distance_mm = mm[11:0];
    pend_q.push_back(r);
  endtask

  // mostly a start followed by a run of ticks, with some stray items
  task automatic add_moves(int count);
    int left, ticks;
    left = count;
    while (left > 0) begin
      if ($urandom_range(9) == 0) begin
        push_item(1'($urandom_range(1)), $urandom_range(4095));
        left--;
      end else begin
        if ($urandom_range(7) == 0) push_item(KIND_START, $urandom_range(4095));
        else push_item(KIND_START, $urandom_range(30));
        ticks = $urandom_range(60, 1);
        for (int i = 0; i < ticks; i++) push_item(KIND_TICK, $urandom);
        left -= ticks + 1;
      end
    end
  endtask

  // block idle: nothing queued, nothing in flight
  task automatic drain();
    @(negedge clk);
    while (pend_q.size() != 0 || req_valid || sample_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: idle ticks, empty move, longest move, a short move run to done
    push_item(KIND_TICK, 0);
    push_item(KIND_START, 0);
    push_item(KIND_TICK, 4095);
    push_item(KIND_START, 4095);
    for (int i = 0; i < 3; i++) push_item(KIND_TICK, 0);
    push_item(KIND_START, 1);
    for (int i = 0; i < 20; i++) push_item(KIND_TICK, 0);
    drain();

    // extremes, then zero rates (act as one), zero speed and scale
    set_regs(65535, 1048575, 10000, 65535);
    add_moves(90);
    drain();
    set_regs(1, 1, 1, 1);
    add_moves(90);
    drain();
    set_regs(500, 0, 0, 256);
    add_moves(60);
    drain();
    set_regs(0, 5000, 100, 0);
    add_moves(40);
    drain();
    for (int p = 0; p < 4; p++) begin
      set_regs($urandom_range(20000, 100), $urandom_range(200000, 1000),
               $urandom_range(1000, 20), $urandom_range(65535, 1));
      add_moves(90);
      drain();
    end
    set_regs(13000, 20000, 100, 28608);
    add_moves(120);
    drain();

    repeat (200) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
